[sv/iee_pkg.sv]
package iee_pkg;

    localparam int DATA_W         = 32;
    localparam int VALUE_DEPTH    = 32;
    localparam int OPERATOR_DEPTH = 32;
    localparam int VCNT_W         = $clog2(VALUE_DEPTH + 1);
    localparam int VADDR_W        = $clog2(VALUE_DEPTH);
    localparam int OCNT_W         = $clog2(OPERATOR_DEPTH + 1);
    localparam int OADDR_W        = $clog2(OPERATOR_DEPTH);
    localparam int DIV_CNT_W      = $clog2(DATA_W);
    localparam int OP_W           = 3;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_STAR  = 8'h2a;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;
    localparam logic [3:0] RADIX      = 4'd10;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_OPEN = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DIVZERO   = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_OP,
        MODE_CLOSE,
        MODE_END
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NUM,
        S_CHAR,
        S_LOOP_RD,
        S_LOOP_OP,
        S_RD_A,
        S_EXEC,
        S_DIV,
        S_WRITE,
        S_POST,
        S_FIN,
        S_OUT
    } state_t;

    function automatic logic rank_hi(input op_t op);
        return (op == OP_MUL) || (op == OP_DIV);
    endfunction

endpackage

[sv/iee_if.sv]
interface iee_in_if import iee_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

interface iee_out_if import iee_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    status_t                  status;

    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface

[sv/iee_ram.sv]
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/iee_divider.sv]
module iee_divider import iee_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    den_reg, den_next;
    logic                 neg_reg, neg_next;
    logic [DATA_W:0]      trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        trial     = {rem_reg, quo_reg[DATA_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            den_next  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DATA_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

[sv/infix_expression_evaluator.sv]
// a digit passes S_IDLE, S_NUM and S_POST; other characters also pass S_CHAR, and each
// operator reduced adds S_LOOP_RD, S_LOOP_OP, S_RD_A, S_EXEC and S_WRITE, with S_DIV
// between the last two when it divides (one quotient bit per cycle); the closing word
// also reads the top value in S_FIN; one word at a time, taken only in S_IDLE
// reset: asynchronous, clears counts, accumulator and error; stack memories keep contents
module infix_expression_evaluator import iee_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    iee_in_if.sink    chars,
    iee_out_if.source results
);

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              innum_reg, innum_next;
    status_t           err_reg, err_next;
    logic [VCNT_W-1:0] vcnt_reg, vcnt_next;
    logic [OCNT_W-1:0] ocnt_reg, ocnt_next;
    op_t               op_reg, op_next;
    op_t               newop_reg, newop_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic              ovalid_reg, ovalid_next;
    logic [DATA_W-1:0] ovalue_reg, ovalue_next;
    status_t           ostatus_reg, ostatus_next;

    logic               v_we, v_re;
    logic [VADDR_W-1:0] v_waddr, v_raddr;
    logic [DATA_W-1:0]  v_wdata, v_rdata;
    logic               o_we, o_re;
    logic [OADDR_W-1:0] o_waddr, o_raddr;
    logic [OP_W-1:0]    o_wdata, o_rdata;
    op_t                top_op;

    logic              div_start, div_done;
    logic [DATA_W-1:0] div_q;

    logic is_digit, is_op, v_full, o_full, reduce_go;

    assign top_op   = op_t'(o_rdata);
    assign is_digit = (char_reg >= CHAR_ZERO) && (char_reg <= CHAR_NINE);
    assign is_op    = (char_reg == CHAR_PLUS) || (char_reg == CHAR_MINUS)
                   || (char_reg == CHAR_STAR) || (char_reg == CHAR_SLASH);
    assign v_full   = (vcnt_reg == VCNT_W'(VALUE_DEPTH));
    assign o_full   = (ocnt_reg == OCNT_W'(OPERATOR_DEPTH));

    // reduce unless the top operator ends the loop for this mode
    always_comb
    begin
        case (mode_reg)
            MODE_OP:
                reduce_go = (top_op != OP_OPEN) && !(!rank_hi(top_op) && rank_hi(newop_reg));
            MODE_CLOSE, MODE_END:
                reduce_go = (top_op != OP_OPEN);
            default:
                reduce_go = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (chars.valid)
                    state_next = S_NUM;
            S_NUM:
                if (err_reg != ST_OK || is_digit)
                    state_next = S_POST;
                else
                    state_next = S_CHAR;
            S_CHAR:
                if (err_reg == ST_OK && (char_reg == CHAR_CLOSE || is_op))
                    state_next = S_LOOP_RD;
                else
                    state_next = S_POST;
            S_LOOP_RD:
                if (err_reg == ST_OK && ocnt_reg != '0)
                    state_next = S_LOOP_OP;
                else if (mode_reg == MODE_END)
                    state_next = S_FIN;
                else
                    state_next = S_POST;
            S_LOOP_OP:
                if (reduce_go && vcnt_reg >= VCNT_W'(2))
                    state_next = S_RD_A;
                else if (mode_reg == MODE_END)
                    state_next = S_FIN;
                else
                    state_next = S_POST;
            S_RD_A:
                state_next = S_EXEC;
            S_EXEC:
                if (op_reg != OP_DIV)
                    state_next = S_WRITE;
                else if (b_reg != '0)
                    state_next = S_DIV;
                else if (mode_reg == MODE_END)
                    state_next = S_FIN;
                else
                    state_next = S_POST;
            S_DIV:
                if (div_done)
                    state_next = S_WRITE;
            S_WRITE:
                state_next = S_LOOP_RD;
            S_POST:
                if (last_reg)
                    state_next = S_LOOP_RD;
                else
                    state_next = S_IDLE;
            S_FIN:
                state_next = S_OUT;
            S_OUT:
                if (!ovalid_reg || results.ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        mode_next    = mode_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        acc_next     = acc_reg;
        innum_next   = innum_reg;
        err_next     = err_reg;
        vcnt_next    = vcnt_reg;
        ocnt_next    = ocnt_reg;
        op_next      = op_reg;
        newop_next   = newop_reg;
        b_next       = b_reg;
        res_next     = res_reg;
        ovalid_next  = ovalid_reg && !results.ready;
        ovalue_next  = ovalue_reg;
        ostatus_next = ostatus_reg;
        v_we         = 1'b0;
        v_waddr      = VADDR_W'(vcnt_reg);
        v_wdata      = acc_reg;
        v_re         = 1'b0;
        v_raddr      = VADDR_W'(vcnt_reg - 1'b1);
        o_we         = 1'b0;
        o_waddr      = OADDR_W'(ocnt_reg);
        o_wdata      = newop_reg;
        o_re         = 1'b0;
        o_raddr      = OADDR_W'(ocnt_reg - 1'b1);
        div_start    = 1'b0;
        chars.ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                chars.ready = 1'b1;
                char_next   = chars.character;
                last_next   = chars.last;
            end
            S_NUM:
                if (err_reg == ST_OK)
                begin
                    if (is_digit)
                    begin
                        acc_next   = DATA_W'(acc_reg * RADIX) + DATA_W'(char_reg - CHAR_ZERO);
                        innum_next = 1'b1;
                    end
                    else if (innum_reg)
                    begin
                        if (v_full)
                            err_next = ST_FULL;
                        else
                        begin
                            v_we      = 1'b1;
                            vcnt_next = vcnt_reg + 1'b1;
                        end
                        acc_next   = '0;
                        innum_next = 1'b0;
                    end
                end
            S_CHAR:
                if (err_reg == ST_OK)
                begin
                    if (char_reg == CHAR_OPEN)
                    begin
                        o_wdata = OP_OPEN;
                        if (o_full)
                            err_next = ST_FULL;
                        else
                        begin
                            o_we      = 1'b1;
                            ocnt_next = ocnt_reg + 1'b1;
                        end
                    end
                    else if (char_reg == CHAR_CLOSE)
                        mode_next = MODE_CLOSE;
                    else
                    begin
                        mode_next = MODE_OP;
                        case (char_reg)
                            CHAR_PLUS:  newop_next = OP_ADD;
                            CHAR_MINUS: newop_next = OP_SUB;
                            CHAR_STAR:  newop_next = OP_MUL;
                            default:    newop_next = OP_DIV;
                        endcase
                    end
                end
            S_LOOP_RD:
                if (err_reg == ST_OK)
                begin
                    if (ocnt_reg != '0)
                        o_re = 1'b1;
                    else if (mode_reg == MODE_CLOSE)
                        err_next = ST_MALFORMED;
                    else if (mode_reg == MODE_OP)
                    begin
                        if (o_full)
                            err_next = ST_FULL;
                        else
                        begin
                            o_we      = 1'b1;
                            ocnt_next = ocnt_reg + 1'b1;
                        end
                    end
                end
            S_LOOP_OP:
                if (reduce_go)
                begin
                    ocnt_next = ocnt_reg - 1'b1;
                    op_next   = top_op;
                    if (vcnt_reg < VCNT_W'(2))
                        err_next = ST_MALFORMED;
                    else
                        v_re = 1'b1;
                end
                else if (mode_reg == MODE_END)
                    err_next = ST_MALFORMED;
                else if (mode_reg == MODE_CLOSE)
                    ocnt_next = ocnt_reg - 1'b1;
                else if (o_full)
                    err_next = ST_FULL;
                else
                begin
                    o_we      = 1'b1;
                    ocnt_next = ocnt_reg + 1'b1;
                end
            S_RD_A:
            begin
                b_next  = v_rdata;
                v_re    = 1'b1;
                v_raddr = VADDR_W'(vcnt_reg - VCNT_W'(2));
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_ADD: res_next = v_rdata + b_reg;
                    OP_SUB: res_next = v_rdata - b_reg;
                    OP_MUL: res_next = DATA_W'(v_rdata * b_reg);
                    default:
                        if (b_reg == '0)
                        begin
                            err_next  = ST_DIVZERO;
                            vcnt_next = vcnt_reg - VCNT_W'(2);
                        end
                        else
                            div_start = 1'b1;
                endcase
            end
            S_DIV:
                res_next = div_q;
            S_WRITE:
            begin
                v_we      = 1'b1;
                v_waddr   = VADDR_W'(vcnt_reg - VCNT_W'(2));
                v_wdata   = res_reg;
                vcnt_next = vcnt_reg - 1'b1;
            end
            S_POST:
                if (last_reg)
                begin
                    mode_next = MODE_END;
                    if (err_reg == ST_OK && innum_reg)
                    begin
                        if (v_full)
                            err_next = ST_FULL;
                        else
                        begin
                            v_we      = 1'b1;
                            vcnt_next = vcnt_reg + 1'b1;
                        end
                        acc_next   = '0;
                        innum_next = 1'b0;
                    end
                end
            S_FIN:
                if (err_reg == ST_OK)
                begin
                    if (vcnt_reg == '0)
                        err_next = ST_MALFORMED;
                    else
                        v_re = 1'b1;
                end
            S_OUT:
                if (!ovalid_reg || results.ready)
                begin
                    ovalid_next  = 1'b1;
                    ovalue_next  = (err_reg == ST_OK) ? v_rdata : '0;
                    ostatus_next = err_reg;
                    err_next     = ST_OK;
                    vcnt_next    = '0;
                    ocnt_next    = '0;
                    acc_next     = '0;
                    innum_next   = 1'b0;
                end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= MODE_OP;
            acc_reg    <= '0;
            innum_reg  <= 1'b0;
            err_reg    <= ST_OK;
            vcnt_reg   <= '0;
            ocnt_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            acc_reg    <= acc_next;
            innum_reg  <= innum_next;
            err_reg    <= err_next;
            vcnt_reg   <= vcnt_next;
            ocnt_reg   <= ocnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg    <= char_next;
        last_reg    <= last_next;
        op_reg      <= op_next;
        newop_reg   <= newop_next;
        b_reg       <= b_next;
        res_reg     <= res_next;
        ovalue_reg  <= ovalue_next;
        ostatus_reg <= ostatus_next;
    end

    assign results.valid  = ovalid_reg;
    assign results.value  = ovalue_reg;
    assign results.status = ostatus_reg;

    iee_ram #(
        .WIDTH (DATA_W),
        .DEPTH (VALUE_DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (v_re),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    iee_ram #(
        .WIDTH (OP_W),
        .DEPTH (OPERATOR_DEPTH)
    ) u_operator_ram (
        .clk   (clk),
        .we    (o_we),
        .waddr (o_waddr),
        .wdata (o_wdata),
        .re    (o_re),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    iee_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (v_rdata),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule

[sim/infix_expression_evaluator_test.sv]
module infix_expression_evaluator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import iee_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] value;
        status_t           status;
    } outcome_t;

    class eval_scoreboard;
        logic [DATA_W-1:0] values [VALUE_DEPTH];
        op_t               ops [OPERATOR_DEPTH];
        int                value_cnt;
        int                op_cnt;
        logic [DATA_W-1:0] acc;
        bit                in_num;
        status_t           err;
        outcome_t          awaited [$];
        int                failures;
        int                checked;
        int                per_status [4];

        function void clear();
            value_cnt = 0;
            op_cnt    = 0;
            acc       = '0;
            in_num    = 0;
            err       = ST_OK;
        endfunction

        function void flag(status_t s);
            if (err == ST_OK)
                err = s;
        endfunction

        function void push_value(logic [DATA_W-1:0] v);
            if (value_cnt >= VALUE_DEPTH)
                flag(ST_FULL);
            else
                values[value_cnt++] = v;
        endfunction

        function void push_op(op_t op);
            if (op_cnt >= OPERATOR_DEPTH)
                flag(ST_FULL);
            else
                ops[op_cnt++] = op;
        endfunction

        function bit high_rank(op_t op);
            return op == OP_MUL || op == OP_DIV;
        endfunction

        function void reduce();
            op_t               op;
            logic [DATA_W-1:0] a, b, r, ma, mb, q;
            op = ops[op_cnt - 1];
            op_cnt--;
            if (value_cnt < 2)
            begin
                flag(ST_MALFORMED);
                return;
            end
            b = values[value_cnt - 1];
            a = values[value_cnt - 2];
            value_cnt -= 2;
            case (op)
                OP_ADD: r = a + b;
                OP_SUB: r = a - b;
                OP_MUL: r = a * b;
                default:
                begin
                    if (b == 0)
                    begin
                        flag(ST_DIVZERO);
                        return;
                    end
                    if (a == 32'h8000_0000 && b == 32'hffff_ffff)
                        r = a;
                    else
                    begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q  = ma / mb;
                        r  = (a[31] != b[31]) ? -q : q;
                    end
                end
            endcase
            values[value_cnt++] = r;
        endfunction

        function void end_number();
            if (in_num)
            begin
                push_value(acc);
                acc    = '0;
                in_num = 0;
            end
        endfunction

        function void take(logic [7:0] c);
            op_t op;
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                acc    = acc * 10 + (c - CHAR_ZERO);
                in_num = 1;
                return;
            end
            end_number();
            if (err != ST_OK)
                return;
            if (c == CHAR_OPEN)
                push_op(OP_OPEN);
            else if (c == CHAR_CLOSE)
            begin
                while (err == ST_OK && op_cnt > 0 && ops[op_cnt - 1] != OP_OPEN)
                    reduce();
                if (err != ST_OK)
                    return;
                if (op_cnt == 0)
                    flag(ST_MALFORMED);
                else
                    op_cnt--;
            end
            else if (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_STAR || c == CHAR_SLASH)
            begin
                op = (c == CHAR_PLUS) ? OP_ADD : (c == CHAR_MINUS) ? OP_SUB :
                     (c == CHAR_STAR) ? OP_MUL : OP_DIV;
                while (err == ST_OK && op_cnt > 0 && ops[op_cnt - 1] != OP_OPEN &&
                       high_rank(ops[op_cnt - 1]) >= high_rank(op))
                    reduce();
                if (err == ST_OK)
                    push_op(op);
            end
        endfunction

        function void note(logic [7:0] c, bit last);
            outcome_t o;
            if (err == ST_OK)
                take(c);
            if (!last)
                return;
            if (err == ST_OK)
                end_number();
            while (err == ST_OK && op_cnt > 0)
            begin
                if (ops[op_cnt - 1] == OP_OPEN)
                    flag(ST_MALFORMED);
                else
                    reduce();
            end
            if (err == ST_OK && value_cnt == 0)
                flag(ST_MALFORMED);
            o.value  = (err == ST_OK) ? values[value_cnt - 1] : '0;
            o.status = err;
            awaited.push_back(o);
            clear();
        endfunction

        function void check(logic [DATA_W-1:0] value, status_t status);
            outcome_t o;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result value %0d status %0d",
                         $time, $signed(value), status);
                failures++;
                return;
            end
            o = awaited.pop_front();
            checked++;
            per_status[o.status]++;
            if (o.status != status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, o.status, status);
                failures++;
            end
            if (o.value !== value)
            begin
                $display("%0t: value expected %0d actual %0d",
                         $time, $signed(o.value), $signed(value));
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    iee_in_if  chars_if ();
    iee_out_if results_if ();

    infix_expression_evaluator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    eval_scoreboard sb;
    int words_sent;
    int exprs_sent;
    int burst_left;
    int stall_mode = 0;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        if (results_if.valid && results_if.ready)
            sb.check(results_if.value, results_if.status);

    // receiver: phases of always ready, light stalls and heavy stalls
    always @(posedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: results_if.ready <= 1'b1;
            1: results_if.ready <= ($urandom_range(0, 3) != 0);
            default: results_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_word(logic [7:0] c, bit last);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0)
            begin
                chars_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        chars_if.valid     <= 1'b1;
        chars_if.character <= c;
        chars_if.last      <= last;
        do
            @(posedge clk);
        while (!chars_if.ready);
        sb.note(c, last);
        words_sent++;
        if (last)
            exprs_sent++;
    endtask

    task automatic send_expr(byte unsigned q [$]);
        foreach (q[i])
            send_word(q[i], i == q.size() - 1);
    endtask

    function automatic void append(ref byte unsigned q [$], input string s);
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
    endfunction

    function automatic string number_text();
        case ($urandom_range(0, 7))
            0: return $sformatf("%0d", $urandom);
            1: return "0";
            2: return $sformatf("%0d", $urandom_range(0, 99999));
            default: return $sformatf("%0d", $urandom_range(0, 99));
        endcase
    endfunction

    function automatic string expr_text(int depth);
        string s, ops;
        int    n;
        ops = "+-*/";
        s   = "";
        n   = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    s = {s, " "};
                s = {s, string'(ops[$urandom_range(0, 3)])};
            end
            if (depth > 0 && $urandom_range(0, 3) == 0)
                s = {s, "(", expr_text(depth - 1), ")"};
            else
                s = {s, number_text()};
        end
        return s;
    endfunction

    task automatic send_text(string s);
        byte unsigned q [$];
        append(q, s);
        send_expr(q);
    endtask

    task automatic send_random();
        byte unsigned q [$];
        int           k;
        append(q, expr_text($urandom_range(0, 4)));
        k = $urandom_range(0, 9);
        if (k == 0)
            q[$urandom_range(0, q.size() - 1)] = $urandom_range(0, 255);
        else if (k == 1 && q.size() > 1)
            q.delete($urandom_range(0, q.size() - 1));
        else if (k == 2)
            q.insert($urandom_range(0, q.size()), $urandom_range(0, 255));
        send_expr(q);
    endtask

    initial
    begin
        byte unsigned q [$];
        string        s;
        sb = new();
        sb.clear();
        burst_left         = 0;
        words_sent         = 0;
        exprs_sent         = 0;
        rst_n              = 1'b0;
        chars_if.valid     = 1'b0;
        chars_if.character = '0;
        chars_if.last      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("0");
        send_text("4294967295");
        send_text("4294967296");
        send_text("12+34*5-6/7");
        send_text("(1+2)*(3-4)/5");
        send_text("100-20-30");
        send_text("0-100/7");
        send_text("7/0");
        send_text("8/(3-3)+)");
        send_text("-5");
        send_text("1++2");
        send_text(")");
        send_text("(1+2");
        send_text("1 2");
        send_text(" ");
        send_text("(0-2147483647-1)/(0-1)");
        send_text("2147483647+1");
        send_text("65536*65536");
        q = {8'h00, "1", 8'h7f, "+", 8'hff, "2", 8'h80};
        send_expr(q);
        s = "";
        for (int i = 0; i < OPERATOR_DEPTH + 1; i++)
            s = {s, "("};
        send_text({s, "1"});
        s = "";
        for (int i = 0; i < VALUE_DEPTH + 1; i++)
            s = {s, "1 "};
        send_text(s);
        s = "";
        for (int i = 0; i < VALUE_DEPTH; i++)
            s = {s, "1+("};
        send_text(s);

        chars_if.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);

        while (words_sent < 1600)
        begin
            send_random();
            if (exprs_sent % 97 == 0)
            begin
                chars_if.valid <= 1'b0;
                while (sb.awaited.size() != 0)
                    @(posedge clk);
            end
        end
        chars_if.valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("%0d characters in %0d expressions, %0d results checked",
                 words_sent, exprs_sent, sb.checked);
        $display("ok %0d, divide by zero %0d, malformed %0d, stack full %0d",
                 sb.per_status[ST_OK], sb.per_status[ST_DIVZERO],
                 sb.per_status[ST_MALFORMED], sb.per_status[ST_FULL]);
        if (sb.failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #6ms;
        $display("timeout");
        $display("Verification failed");
        $finish;
    end
endmodule

[filelist.f]
sv/iee_pkg.sv
sv/iee_if.sv
sv/iee_ram.sv
sv/iee_divider.sv
sv/infix_expression_evaluator.sv
sim/infix_expression_evaluator_test.sv
